// ----- design/rrps_pkg.sv -----
// Shared constants, types and register codes for the ROI remap pixel sampler.
`default_nettype none
package rrps_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int INT_BITS   = 12;
  localparam int COORD_BITS = INT_BITS + FRAC_BITS;
  localparam int PIX_BITS   = 8;
  localparam int W_BITS     = FRAC_BITS + 1;          // weight, 0 .. 2^FRAC_BITS
  localparam int ROW_BITS   = FRAC_BITS + PIX_BITS;   // one horizontal blend
  localparam int SUM_BITS   = 2 * FRAC_BITS + PIX_BITS + 1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_LEFT     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_TOP      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROI_BOTTOM   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_USE_BILINEAR = 3'd4;

  localparam logic [FRAC_BITS-1:0] HALF_W = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [W_BITS-1:0]    ONE_W  = W_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] roi_left;
    logic [COORD_BITS-1:0] roi_right;
    logic [COORD_BITS-1:0] roi_top;
    logic [COORD_BITS-1:0] roi_bottom;
    logic                  use_bilinear;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [PIX_BITS-1:0]   pix_top_left;
    logic [PIX_BITS-1:0]   pix_top_right;
    logic [PIX_BITS-1:0]   pix_bottom_left;
    logic [PIX_BITS-1:0]   pix_bottom_right;
    logic                  frame_end;
  } item_t;

  typedef struct packed {
    logic                bilinear;
    logic                in_roi;
    logic                last;
    logic [PIX_BITS-1:0] near_pix;
    logic [W_BITS-1:0]   wx0;
    logic [W_BITS-1:0]   wx1;
    logic [W_BITS-1:0]   wy0;
    logic [W_BITS-1:0]   wy1;
    logic [PIX_BITS-1:0] tl;
    logic [PIX_BITS-1:0] tr;
    logic [PIX_BITS-1:0] bl;
    logic [PIX_BITS-1:0] br;
  } s1_t;

  typedef struct packed {
    logic                bilinear;
    logic                in_roi;
    logic                last;
    logic [PIX_BITS-1:0] near_pix;
    logic [ROW_BITS-1:0] top_row;
    logic [ROW_BITS-1:0] bot_row;
    logic [W_BITS-1:0]   wy0;
    logic [W_BITS-1:0]   wy1;
  } s2_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_pixel;
    logic                inside_region;
    logic                frame_last;
  } res_t;

endpackage
`default_nettype wire

// ----- design/rrps_if.sv -----
// Valid/ready channel interfaces for coordinate beats and sample beats.
`default_nettype none
interface rrps_coord_if;
  logic                              valid;
  logic                              ready;
  logic [rrps_pkg::COORD_BITS-1:0]   src_x;
  logic [rrps_pkg::COORD_BITS-1:0]   src_y;
  logic [rrps_pkg::PIX_BITS-1:0]     pix_top_left;
  logic [rrps_pkg::PIX_BITS-1:0]     pix_top_right;
  logic [rrps_pkg::PIX_BITS-1:0]     pix_bottom_left;
  logic [rrps_pkg::PIX_BITS-1:0]     pix_bottom_right;
  logic                              frame_end;

  modport source (output valid, src_x, src_y, pix_top_left, pix_top_right,
                  pix_bottom_left, pix_bottom_right, frame_end, input ready);
  modport sink   (input valid, src_x, src_y, pix_top_left, pix_top_right,
                  pix_bottom_left, pix_bottom_right, frame_end, output ready);
endinterface

interface rrps_sample_if;
  logic                          valid;
  logic                          ready;
  logic [rrps_pkg::PIX_BITS-1:0] out_pixel;
  logic                          inside_region;
  logic                          frame_last;

  modport source (output valid, out_pixel, inside_region, frame_last, input ready);
  modport sink   (input valid, out_pixel, inside_region, frame_last, output ready);
endinterface
`default_nettype wire

// ----- design/rrps_front.sv -----
// Stage 1: region test, fractional weights and nearest-pixel pick.
`default_nettype none
module rrps_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rrps_pkg::cfg_t  cfg,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire rrps_pkg::item_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output rrps_pkg::s1_t      dn_data
);

  logic [rrps_pkg::FRAC_BITS-1:0] fx;
  logic [rrps_pkg::FRAC_BITS-1:0] fy;
  logic                           ux;
  logic                           uy;
  rrps_pkg::s1_t                  s1_next;

  assign fx = up_data.src_x[rrps_pkg::FRAC_BITS-1:0];
  assign fy = up_data.src_y[rrps_pkg::FRAC_BITS-1:0];

  // half to even: exactly one half goes up only from an odd integer part
  assign ux = (fx > rrps_pkg::HALF_W) ||
              ((fx == rrps_pkg::HALF_W) && up_data.src_x[rrps_pkg::FRAC_BITS]);
  assign uy = (fy > rrps_pkg::HALF_W) ||
              ((fy == rrps_pkg::HALF_W) && up_data.src_y[rrps_pkg::FRAC_BITS]);

  always_comb begin
    s1_next.bilinear = cfg.use_bilinear;
    s1_next.in_roi   = (up_data.src_x >= cfg.roi_left) && (up_data.src_x <= cfg.roi_right) &&
                       (up_data.src_y >= cfg.roi_top)  && (up_data.src_y <= cfg.roi_bottom);
    s1_next.last     = up_data.frame_end;
    if (uy) begin
      s1_next.near_pix = ux ? up_data.pix_bottom_right : up_data.pix_bottom_left;
    end else begin
      s1_next.near_pix = ux ? up_data.pix_top_right : up_data.pix_top_left;
    end
    s1_next.wx0 = rrps_pkg::ONE_W - {1'b0, fx};
    s1_next.wx1 = {1'b0, fx};
    s1_next.wy0 = rrps_pkg::ONE_W - {1'b0, fy};
    s1_next.wy1 = {1'b0, fy};
    s1_next.tl  = up_data.pix_top_left;
    s1_next.tr  = up_data.pix_top_right;
    s1_next.bl  = up_data.pix_bottom_left;
    s1_next.br  = up_data.pix_bottom_right;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= s1_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/rrps_hblend.sv -----
// Stage 2: horizontal blend of the top and bottom pixel pairs.
`default_nettype none
module rrps_hblend (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire rrps_pkg::s1_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output rrps_pkg::s2_t      dn_data
);

  localparam int RW = rrps_pkg::ROW_BITS + 1;

  logic [RW-1:0] top_sum;
  logic [RW-1:0] bot_sum;
  rrps_pkg::s2_t s2_next;

  assign top_sum = RW'(up_data.wx0) * RW'(up_data.tl) + RW'(up_data.wx1) * RW'(up_data.tr);
  assign bot_sum = RW'(up_data.wx0) * RW'(up_data.bl) + RW'(up_data.wx1) * RW'(up_data.br);

  always_comb begin
    s2_next.bilinear = up_data.bilinear;
    s2_next.in_roi   = up_data.in_roi;
    s2_next.last     = up_data.last;
    s2_next.near_pix = up_data.near_pix;
    // weights sum to 2^FRAC_BITS, so a row never exceeds 255 << FRAC_BITS
    s2_next.top_row  = top_sum[rrps_pkg::ROW_BITS-1:0];
    s2_next.bot_row  = bot_sum[rrps_pkg::ROW_BITS-1:0];
    s2_next.wy0      = up_data.wy0;
    s2_next.wy1      = up_data.wy1;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= s2_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/rrps_vblend.sv -----
// Stage 3: vertical blend, result select and output register.
`default_nettype none
module rrps_vblend (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire rrps_pkg::s2_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output rrps_pkg::res_t     dn_data
);

  localparam int SW = rrps_pkg::SUM_BITS;

  logic [SW-1:0]                 sum;
  logic [rrps_pkg::PIX_BITS-1:0] blend;
  rrps_pkg::res_t                res_next;

  assign sum = SW'(up_data.top_row) * SW'(up_data.wy0) +
               SW'(up_data.bot_row) * SW'(up_data.wy1);
  assign blend = sum[2*rrps_pkg::FRAC_BITS +: rrps_pkg::PIX_BITS];

  always_comb begin
    res_next.inside_region = up_data.in_roi;
    res_next.frame_last    = up_data.last;
    if (!up_data.in_roi) begin
      res_next.out_pixel = '0;
    end else if (up_data.bilinear) begin
      res_next.out_pixel = blend;
    end else begin
      res_next.out_pixel = up_data.near_pix;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/roi_remap_pixel_sampler_core.sv -----
// Top level of the ROI remap pixel sampler: config registers and three-stage pipeline.
// One output pixel per clock, sustained while the sample port is ready. A coordinate
// beat passes through three register stages in order (region test and weights,
// horizontal blend, vertical blend with the output register). Each stage holds its
// beat under backpressure and takes a new one as soon as it is empty or its successor
// moves, so bubbles close up while the output waits. Bilinear weights are 8-bit
// fractions and the weighted sum is truncated; nearest sampling rounds half to even.
// Write the region bounds and mode only while no beat is in flight.
`default_nettype none
module roi_remap_pixel_sampler_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [rrps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rrps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  rrps_coord_if.sink                                coord,
  rrps_sample_if.source                             sample
);

  rrps_pkg::cfg_t  cfg;
  rrps_pkg::item_t item;
  rrps_pkg::s1_t   s1_data;
  rrps_pkg::s2_t   s2_data;
  rrps_pkg::res_t  res;
  logic            s1_valid;
  logic            s1_ready;
  logic            s2_valid;
  logic            s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_left     <= '0;
      cfg.roi_right    <= '1;
      cfg.roi_top      <= '0;
      cfg.roi_bottom   <= '1;
      cfg.use_bilinear <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rrps_pkg::CFG_ROI_LEFT:     cfg.roi_left     <= cfg_data;
        rrps_pkg::CFG_ROI_RIGHT:    cfg.roi_right    <= cfg_data;
        rrps_pkg::CFG_ROI_TOP:      cfg.roi_top      <= cfg_data;
        rrps_pkg::CFG_ROI_BOTTOM:   cfg.roi_bottom   <= cfg_data;
        rrps_pkg::CFG_USE_BILINEAR: cfg.use_bilinear <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.src_x            = coord.src_x;
    item.src_y            = coord.src_y;
    item.pix_top_left     = coord.pix_top_left;
    item.pix_top_right    = coord.pix_top_right;
    item.pix_bottom_left  = coord.pix_bottom_left;
    item.pix_bottom_right = coord.pix_bottom_right;
    item.frame_end        = coord.frame_end;
  end

  rrps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (coord.valid),
    .up_ready (coord.ready),
    .up_data  (item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  rrps_hblend u_hblend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  rrps_vblend u_vblend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (sample.valid),
    .dn_ready (sample.ready),
    .dn_data  (res)
  );

  assign sample.out_pixel     = res.out_pixel;
  assign sample.inside_region = res.inside_region;
  assign sample.frame_last    = res.frame_last;

  // an empty first stage always takes a beat
  a_front_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> coord.ready)
    else $error("coordinate port stalled with empty first stage");

  // a stalled middle stage keeps its beat
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
    else $error("middle stage dropped or changed a stalled beat");

  // outside the region the sample is forced to zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    sample.valid && !sample.inside_region |-> sample.out_pixel == '0)
    else $error("outside sample carries a nonzero pixel");

  // a beat leaving stage two with the output free shows up at the output next cycle
  a_s3_load: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_ready |=> sample.valid)
    else $error("beat lost between stage two and output");

endmodule
`default_nettype wire
